[hw/rtl/srecord_line_checker_defines.svh]
// ---------------------------------------------------------------------------
// S-record line checker assertion macros
// Shared property forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SRECORD_LINE_CHECKER_DEFINES_SVH
`define SRECORD_LINE_CHECKER_DEFINES_SVH

// same-cycle implication under reset
`define SLC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define SLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/slc_pkg.sv]
// ---------------------------------------------------------------------------
// S-record line checker package
// Types, character constants and the hex digit decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package slc_pkg;

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_COUNT = 2'd1,
    FLT_CHAR  = 2'd2,
    FLT_SUM   = 2'd3
  } fault_t;

  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [7:0] SUM_OK    = 8'hFF;
  localparam logic [3:0] HEX_A_VAL = 4'd10;
  localparam int unsigned OUT_W    = 16;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t    n;
    logic [7:0] ofs;
    ofs = c - CHAR_A;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      n.bad = 1'b0;
      n.val = c[3:0];
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      n.bad = 1'b0;
      n.val = ofs[3:0] + HEX_A_VAL;
    end else begin
      n.bad = 1'b1;
      n.val = 4'd0;
    end
    return n;
  endfunction

endpackage

[hw/rtl/srecord_line_checker.sv]
// ---------------------------------------------------------------------------
// S-record line checker: one item per cycle when not stalled by a held verdict;
// the registered verdict appears in the cycle after the accepted line-end item.
// Throughput: 1 item per cycle while in_tready is high; one state update per character.
// Reset: synchronous active-low rst_n clears line state and the output valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srecord_line_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] char_code
  input  logic                      in_tlast,   // line_end
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [slc_pkg::OUT_W-1:0] out_tdata   // record_ok, fault[1:0],
                                                // record_type[3:0],
                                                // declared_bytes[7:0], pad
);
  import slc_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] held_r, held_nxt;
  logic       held_bad_r, held_bad_nxt;
  logic       half_r, half_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] count_r, count_nxt;
  logic [8:0] pairs_r, pairs_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic       err_r, err_nxt;
  logic [3:0] type_r, type_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic       accept;
  logic [7:0] c;
  nibble_t    nib;
  logic [7:0] pair_byte;
  fault_t     fault;
  logic       rec_ok;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign c          = in_tdata;
  assign nib        = hex_nibble(c);
  assign pair_byte  = (held_bad_r || nib.bad) ? 8'd0 : {held_r, nib.val};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (seen_r < 2'd2 || {1'b0, count_r} != pairs_r) begin
      fault = FLT_COUNT;
    end else if (err_r || phase_r != PH_BODY) begin
      fault = FLT_CHAR;
    end else if (sum_r != SUM_OK) begin
      fault = FLT_SUM;
    end else begin
      fault = FLT_NONE;
    end
    rec_ok = (fault == FLT_NONE);
  end

  always_comb begin
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    held_bad_nxt  = held_bad_r;
    half_nxt      = half_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    pairs_nxt     = pairs_r;
    seen_nxt      = seen_r;
    err_nxt       = err_r;
    type_nxt      = type_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (accept && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, count_r, type_r, fault, rec_ok};
      phase_nxt     = PH_SYNC;
      held_nxt      = 4'd0;
      held_bad_nxt  = 1'b0;
      half_nxt      = 1'b0;
      sum_nxt       = 8'd0;
      count_nxt     = 8'd0;
      pairs_nxt     = 9'd0;
      seen_nxt      = 2'd0;
      err_nxt       = 1'b0;
      type_nxt      = 4'd0;
    end else if (accept) begin
      case (phase_r)
        PH_SYNC: begin
          if (c != CHAR_S) err_nxt = 1'b1;
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          if (c inside {[CHAR_0:CHAR_9]}) begin
            type_nxt = c[3:0];
          end else begin
            type_nxt = 4'd0;
            err_nxt  = 1'b1;
          end
          phase_nxt = PH_BODY;
        end
        PH_BODY: begin
          if (nib.bad) err_nxt = 1'b1;
          if (!half_r) begin
            held_nxt     = nib.val;
            held_bad_nxt = nib.bad;
            half_nxt     = 1'b1;
          end else begin
            sum_nxt = sum_r + pair_byte;
            if (seen_r == 2'd1) begin
              count_nxt = pair_byte;
            end else if (!pairs_r[8]) begin
              pairs_nxt = pairs_r + 9'd1;
            end
            half_nxt     = 1'b0;
            held_bad_nxt = 1'b0;
          end
          if (seen_r < 2'd2) seen_nxt = seen_r + 2'd1;
        end
        default: begin
          phase_nxt = PH_SYNC;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      held_r      <= 4'd0;
      held_bad_r  <= 1'b0;
      half_r      <= 1'b0;
      sum_r       <= 8'd0;
      count_r     <= 8'd0;
      pairs_r     <= 9'd0;
      seen_r      <= 2'd0;
      err_r       <= 1'b0;
      type_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      held_bad_r  <= held_bad_nxt;
      half_r      <= half_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      pairs_r     <= pairs_nxt;
      seen_r      <= seen_nxt;
      err_r       <= err_nxt;
      type_r      <= type_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

[hw/rtl/slc_checker.sv]
// ---------------------------------------------------------------------------
// S-record line checker port checker
// Watches the top-level ports and flags verdict and handshake slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "srecord_line_checker_defines.svh"

module slc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      in_tlast,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [slc_pkg::OUT_W-1:0] out_tdata
);
  import slc_pkg::*;

  `SLC_ASSERT_NOW(a_ok_matches_fault, clk, rst_n, out_tvalid, (out_tdata[0] == (out_tdata[2:1] == FLT_NONE)), "record_ok disagrees with fault")
  `SLC_ASSERT_NOW(a_type_decimal, clk, rst_n, out_tvalid, (out_tdata[6:3] <= 4'd9), "record_type is not a decimal digit")
  `SLC_ASSERT_NOW(a_pad_zero, clk, rst_n, out_tvalid, (out_tdata[OUT_W-1] == 1'b0), "out_tdata padding bit set")
  `SLC_ASSERT_NEXT(a_verdict_follows_end, clk, rst_n, (in_tvalid && in_tready && in_tlast), out_tvalid, "no verdict after line end")
  `SLC_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready), (out_tvalid && $stable(out_tdata)), "stalled result changed")

endmodule

bind srecord_line_checker slc_checker u_slc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
